### hw/rtl/bat_alarm_pkg.sv
// shared types and constants of the battery low voltage alarm
`default_nettype none

package bat_alarm_pkg;

	// largest cell count that detection reports
	localparam int MAX_CELLS = 8;

	// step counter holds up to MAX_CELLS + 1
	localparam int CNT_W = $clog2(MAX_CELLS + 2);
	// accumulator holds MAX_CELLS * 65535 and (MAX_CELLS + 1) * 8191
	localparam int ACC_W = 16 + $clog2(MAX_CELLS + 2);

	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [ACC_W-1:0] acc_t;

	// command codes
	localparam logic [1:0] OP_SAMPLE = 2'd0;
	localparam logic [1:0] OP_DETECT = 2'd1;
	localparam logic [1:0] OP_TICK   = 2'd2;

	// event codes
	localparam logic [1:0] EV_NONE    = 2'd0;
	localparam logic [1:0] EV_RAISED  = 2'd1;
	localparam logic [1:0] EV_CLEARED = 2'd2;

	// register indexes
	localparam logic [2:0] REG_DEFAULT_THRESHOLD = 3'd0;
	localparam logic [2:0] REG_HOLD              = 3'd1;
	localparam logic [2:0] REG_CELL_FULL         = 3'd2;
	localparam logic [2:0] REG_CELL_ALARM        = 3'd3;
	localparam logic [2:0] REG_BEEP_HALF_PERIOD  = 3'd4;

	// reset values of the registers
	localparam logic [15:0] RST_DEFAULT_THRESHOLD = 16'd3300;
	localparam logic [15:0] RST_HOLD              = 16'd5000;
	localparam logic [15:0] RST_CELL_FULL         = 16'd4200;
	localparam logic [12:0] RST_CELL_ALARM        = 13'd3500;
	localparam logic [15:0] RST_BEEP_HALF_PERIOD  = 16'd1000;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DETECT,
		ST_SCALE,
		ST_RESP
	} state_t;

endpackage

`default_nettype wire

### hw/rtl/bat_alarm_if.sv
// valid/ready channel interfaces for commands and results
`default_nettype none

interface bat_alarm_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [15:0] sample_mv;

	modport source (output valid, output op, output sample_mv, input ready);
	modport sink (input valid, input op, input sample_mv, output ready);
endinterface

interface bat_alarm_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  event_res;
	logic        alarm_active;
	logic        tone_on;
	logic [15:0] threshold_mv;

	modport source (output valid, output event_res, output alarm_active, output tone_on,
		output threshold_mv, input ready);
	modport sink (input valid, input event_res, input alarm_active, input tone_on,
		input threshold_mv, output ready);
endinterface

`default_nettype wire

### hw/rtl/battery_low_voltage_alarm.sv
// battery low voltage alarm with cell count detection
//
// channel    dir  payload                                          transaction
// in_ch      in   op, sample_mv                                    valid & ready
// out_ch     out  event_res, alarm_active, tone_on, threshold_mv   valid & ready
// cfg        in   cfg_we, cfg_index, cfg_data                      cfg_we
//
// sample, tick, unused and no-sample detection commands go from idle straight to the
// response state; cell detection first passes the detect state, in which the one
// shared adder walks the cell multiples, and then the scale state, in which the same
// adder sums the per cell voltage, before it reaches the response state.
// one command is in flight at a time; in_ch.ready is high only when idle.
// a result waits in the output register while out_ch.ready is low.
// arst_n clears the sequencer, the alarm state and loads register defaults.
`default_nettype none

module battery_low_voltage_alarm (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [15:0]        cfg_data,
	bat_alarm_cmd_if.sink           in_ch,
	bat_alarm_res_if.source         out_ch
);

	// configuration registers
	logic [15:0] hold_q;
	logic [15:0] cell_full_q;
	logic [12:0] cell_alarm_q;
	logic [15:0] beep_half_q;

	// alarm state
	logic [15:0] last_sample_q;
	logic [15:0] threshold_q;
	logic        low_pending_q;
	logic [15:0] low_elapsed_q;
	logic        alarm_q;
	logic [15:0] beep_count_q;
	logic        tone_q;
	logic [1:0]  event_q;

	// sequencer and shared adder
	bat_alarm_pkg::state_t state_q, state_d;
	bat_alarm_pkg::cnt_t   step_q;
	bat_alarm_pkg::cnt_t   cells_q;
	bat_alarm_pkg::acc_t   acc_q;
	bat_alarm_pkg::acc_t   addend;
	bat_alarm_pkg::acc_t   sum;

	// output register
	logic        out_valid_q;
	logic [1:0]  out_event_q;
	logic        out_alarm_q;
	logic        out_tone_q;
	logic [15:0] out_threshold_q;

	logic        cmd_take;
	logic        res_load;
	logic        last_detect;
	logic        last_scale;
	logic [15:0] beep_next;

	// shared adder: cell multiples while detecting, per cell voltage while scaling
	always_comb begin
		if (state_q == bat_alarm_pkg::ST_SCALE) begin
			addend = bat_alarm_pkg::acc_t'(cell_alarm_q);
		end else begin
			addend = bat_alarm_pkg::acc_t'(cell_full_q);
		end
		sum = acc_q + addend;
	end

	assign cmd_take    = in_ch.valid && in_ch.ready;
	assign res_load    = (state_q == bat_alarm_pkg::ST_RESP) && (!out_valid_q || out_ch.ready);
	assign last_detect = step_q == bat_alarm_pkg::cnt_t'(bat_alarm_pkg::MAX_CELLS);
	assign last_scale  = step_q == bat_alarm_pkg::cnt_t'(1);
	assign beep_next   = beep_count_q + 16'd1;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			bat_alarm_pkg::ST_IDLE: begin
				if (cmd_take) begin
					if (in_ch.op == bat_alarm_pkg::OP_DETECT && last_sample_q != 16'd0) begin
						state_d = bat_alarm_pkg::ST_DETECT;
					end else begin
						state_d = bat_alarm_pkg::ST_RESP;
					end
				end
			end
			bat_alarm_pkg::ST_DETECT: begin
				if (last_detect) begin
					state_d = bat_alarm_pkg::ST_SCALE;
				end
			end
			bat_alarm_pkg::ST_SCALE: begin
				if (last_scale) begin
					state_d = bat_alarm_pkg::ST_RESP;
				end
			end
			bat_alarm_pkg::ST_RESP: begin
				if (res_load) begin
					state_d = bat_alarm_pkg::ST_IDLE;
				end
			end
			default: state_d = bat_alarm_pkg::ST_IDLE;
		endcase
	end

	// handshake outputs
	always_comb begin
		in_ch.ready = state_q == bat_alarm_pkg::ST_IDLE;
		out_ch.valid        = out_valid_q;
		out_ch.event_res    = out_event_q;
		out_ch.alarm_active = out_alarm_q;
		out_ch.tone_on      = out_tone_q;
		out_ch.threshold_mv = out_threshold_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bat_alarm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration, command handling and detection datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q              <= bat_alarm_pkg::RST_HOLD;
			cell_full_q         <= bat_alarm_pkg::RST_CELL_FULL;
			cell_alarm_q        <= bat_alarm_pkg::RST_CELL_ALARM;
			beep_half_q         <= bat_alarm_pkg::RST_BEEP_HALF_PERIOD;
			last_sample_q       <= '0;
			threshold_q         <= bat_alarm_pkg::RST_DEFAULT_THRESHOLD;
			low_pending_q       <= 1'b0;
			low_elapsed_q       <= '0;
			alarm_q             <= 1'b0;
			beep_count_q        <= '0;
			tone_q              <= 1'b0;
			event_q             <= bat_alarm_pkg::EV_NONE;
			step_q              <= '0;
			cells_q             <= '0;
			acc_q               <= '0;
		end else begin
			// register writes are to arrive only while idle; the block itself does not enforce it
			if (cfg_we) begin
				case (cfg_index)
					bat_alarm_pkg::REG_DEFAULT_THRESHOLD: threshold_q <= cfg_data;
					bat_alarm_pkg::REG_HOLD:             hold_q       <= cfg_data;
					bat_alarm_pkg::REG_CELL_FULL:        cell_full_q  <= cfg_data;
					bat_alarm_pkg::REG_CELL_ALARM:       cell_alarm_q <= cfg_data[12:0];
					bat_alarm_pkg::REG_BEEP_HALF_PERIOD: beep_half_q  <= cfg_data;
					default: ;
				endcase
			end

			case (state_q)
				bat_alarm_pkg::ST_IDLE: begin
					if (cmd_take) begin
						event_q <= bat_alarm_pkg::EV_NONE;
						step_q  <= bat_alarm_pkg::cnt_t'(1);
						cells_q <= '0;
						acc_q   <= '0;
						case (in_ch.op)
							// voltage sample against the threshold
							bat_alarm_pkg::OP_SAMPLE: begin
								last_sample_q <= in_ch.sample_mv;
								if (in_ch.sample_mv <= threshold_q) begin
									if (!low_pending_q) begin
										low_pending_q <= 1'b1;
										low_elapsed_q <= '0;
									end else if (low_elapsed_q >= hold_q && !alarm_q) begin
										alarm_q      <= 1'b1;
										beep_count_q <= '0;
										tone_q       <= 1'b0;
										event_q      <= bat_alarm_pkg::EV_RAISED;
									end
								end else begin
									if (alarm_q) begin
										event_q <= bat_alarm_pkg::EV_CLEARED;
									end
									alarm_q       <= 1'b0;
									low_pending_q <= 1'b0;
									low_elapsed_q <= '0;
									beep_count_q  <= '0;
									tone_q        <= 1'b0;
								end
							end
							// millisecond tick: low timer and tone
							bat_alarm_pkg::OP_TICK: begin
								if (low_pending_q && low_elapsed_q != 16'hFFFF) begin
									low_elapsed_q <= low_elapsed_q + 16'd1;
								end
								if (alarm_q) begin
									if (beep_next >= beep_half_q) begin
										beep_count_q <= '0;
										tone_q       <= !tone_q;
									end else begin
										beep_count_q <= beep_next;
									end
								end
							end
							default: ;
						endcase
					end
				end
				// count cells: compare sample with c * cell_full for c = 1..MAX_CELLS
				bat_alarm_pkg::ST_DETECT: begin
					if (bat_alarm_pkg::acc_t'(last_sample_q) > sum) begin
						cells_q <= cells_q + bat_alarm_pkg::cnt_t'(1);
					end
					if (last_detect) begin
						acc_q  <= '0;
						step_q <= (bat_alarm_pkg::acc_t'(last_sample_q) > sum) ?
							cells_q + bat_alarm_pkg::cnt_t'(2) : cells_q + bat_alarm_pkg::cnt_t'(1);
					end else begin
						acc_q  <= sum;
						step_q <= step_q + bat_alarm_pkg::cnt_t'(1);
					end
				end
				// threshold = (cells + 1) * cell_alarm by repeated addition, saturated at 16'hFFFF
				bat_alarm_pkg::ST_SCALE: begin
					acc_q  <= sum;
					step_q <= step_q - bat_alarm_pkg::cnt_t'(1);
					if (last_scale) begin
						if (|sum[bat_alarm_pkg::ACC_W-1:16]) begin
							threshold_q <= 16'hFFFF;
						end else begin
							threshold_q <= sum[15:0];
						end
					end
				end
				default: ;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			out_event_q     <= event_q;
			out_alarm_q     <= alarm_q;
			out_tone_q      <= alarm_q && tone_q;
			out_threshold_q <= threshold_q;
		end
	end

endmodule

`default_nettype wire

### tb/battery_low_voltage_alarm_tb.sv
// testbench for the battery low voltage alarm: predicted status checked per transaction
`timescale 1ns / 100ps

module battery_low_voltage_alarm_tb;

	// op code that the block treats as no command
	localparam logic [1:0] OP_UNUSED = 2'd3;
	// longest command is cell detection
	localparam int DRAIN_CYCLES = 2 * bat_alarm_pkg::MAX_CELLS + 8;
	localparam int TIMEOUT_NS = 10_000_000;
	localparam int PHASE_ITEMS = 205;
	localparam int RANDOM_PHASES = 8;

	typedef struct {
		logic [1:0]  event_res;
		logic        alarm_active;
		logic        tone_on;
		logic [15:0] threshold_mv;
	} alarm_status_t;

	// tracks the alarm state and holds the status each command must produce
	class alarm_checker;
		bit [15:0] hold_ms;
		bit [15:0] cell_full;
		bit [12:0] cell_alarm;
		bit [15:0] beep_half;
		bit [15:0] last_mv;
		bit [15:0] thr;
		bit        low_pending;
		bit [15:0] low_elapsed;
		bit        alarm;
		bit [15:0] beep_cnt;
		bit        tone;
		alarm_status_t status_due[$];
		int        errors;

		function new();
			hold_ms     = bat_alarm_pkg::RST_HOLD;
			cell_full   = bat_alarm_pkg::RST_CELL_FULL;
			cell_alarm  = bat_alarm_pkg::RST_CELL_ALARM;
			beep_half   = bat_alarm_pkg::RST_BEEP_HALF_PERIOD;
			last_mv     = '0;
			thr         = bat_alarm_pkg::RST_DEFAULT_THRESHOLD;
			low_pending = 1'b0;
			low_elapsed = '0;
			alarm       = 1'b0;
			beep_cnt    = '0;
			tone        = 1'b0;
			errors      = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [15:0] data);
			case (idx)
				bat_alarm_pkg::REG_DEFAULT_THRESHOLD: thr = data;
				bat_alarm_pkg::REG_HOLD:             hold_ms = data;
				bat_alarm_pkg::REG_CELL_FULL:        cell_full = data;
				bat_alarm_pkg::REG_CELL_ALARM:       cell_alarm = data[12:0];
				bat_alarm_pkg::REG_BEEP_HALF_PERIOD: beep_half = data;
				default: ;
			endcase
		endfunction

		// threshold from the cell count of the last sample
		function void detect_cells();
			int cells;
			int t;
			cells = 0;
			if (last_mv == 0)
				return;
			for (int c = 1; c <= bat_alarm_pkg::MAX_CELLS; c++)
				if (int'(last_mv) > c * int'(cell_full))
					cells++;
			t = (cells + 1) * int'(cell_alarm);
			thr = (t > 65535) ? 16'hffff : t[15:0];
		endfunction

		function void note_command(logic [1:0] op, logic [15:0] mv);
			alarm_status_t s;
			s.event_res = bat_alarm_pkg::EV_NONE;
			case (op)
				bat_alarm_pkg::OP_SAMPLE: begin
					last_mv = mv;
					if (mv <= thr) begin
						if (!low_pending) begin
							low_pending = 1'b1;
							low_elapsed = '0;
						end else if (low_elapsed >= hold_ms && !alarm) begin
							alarm = 1'b1;
							beep_cnt = '0;
							tone = 1'b0;
							s.event_res = bat_alarm_pkg::EV_RAISED;
						end
					end else begin
						if (alarm)
							s.event_res = bat_alarm_pkg::EV_CLEARED;
						alarm = 1'b0;
						low_pending = 1'b0;
						low_elapsed = '0;
						beep_cnt = '0;
						tone = 1'b0;
					end
				end
				bat_alarm_pkg::OP_DETECT: detect_cells();
				bat_alarm_pkg::OP_TICK: begin
					if (low_pending && low_elapsed != 16'hffff)
						low_elapsed++;
					if (alarm) begin
						beep_cnt++;
						if (beep_cnt >= beep_half) begin
							beep_cnt = '0;
							tone = !tone;
						end
					end
				end
				default: ;
			endcase
			s.alarm_active = alarm;
			s.tone_on = alarm && tone;
			s.threshold_mv = thr;
			status_due.push_back(s);
		endfunction

		task report(string msg);
			$display("%0t mismatch: %s", $realtime, msg);
			errors++;
		endtask

		task check_status(alarm_status_t got);
			alarm_status_t want;
			if (status_due.size() == 0) begin
				report("status transaction with none expected");
				return;
			end
			want = status_due.pop_front();
			if (got.event_res !== want.event_res)
				report($sformatf("event_res got %0d want %0d", got.event_res, want.event_res));
			if (got.alarm_active !== want.alarm_active)
				report($sformatf("alarm_active got %0b want %0b",
					got.alarm_active, want.alarm_active));
			if (got.tone_on !== want.tone_on)
				report($sformatf("tone_on got %0b want %0b", got.tone_on, want.tone_on));
			if (got.threshold_mv !== want.threshold_mv)
				report($sformatf("threshold_mv got %0d want %0d",
					got.threshold_mv, want.threshold_mv));
		endtask

		function int pending();
			return status_due.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;

	bat_alarm_cmd_if in_ch();
	bat_alarm_res_if out_ch();

	alarm_checker chk = new();

	int burst_left;
	bit steady;
	int phase_items;

	battery_low_voltage_alarm dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#(TIMEOUT_NS);
		$display("[battery_low_voltage_alarm] ERROR");
		$finish;
	end

	// receiver: quiet stretches and stretches of random stalls
	initial begin
		int stall_left;
		int mode_left;
		bit stalling;
		stall_left = 0;
		mode_left = 0;
		stalling = 1'b0;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (mode_left == 0) begin
				stalling = $urandom_range(0, 2) != 0;
				mode_left = $urandom_range(50, 300);
			end
			mode_left--;
			if (stall_left > 0) begin
				stall_left--;
				out_ch.ready <= 1'b0;
			end else if (stalling && $urandom_range(0, 3) == 0) begin
				stall_left = $urandom_range(0, 7);
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// status monitor
	always @(posedge clk) begin
		alarm_status_t got;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got.event_res = out_ch.event_res;
			got.alarm_active = out_ch.alarm_active;
			got.tone_on = out_ch.tone_on;
			got.threshold_mv = out_ch.threshold_mv;
			chk.check_status(got);
		end
	end

	// drop valid
	task automatic idle_input(int n);
		repeat (n) begin
			@(negedge clk);
			in_ch.valid <= 1'b0;
		end
	endtask

	// one command transaction, with bursts and gaps ahead of it
	task automatic issue(logic [1:0] op, logic [15:0] mv);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			if (!steady)
				idle_input($urandom_range(1, 8));
		end
		burst_left--;
		@(negedge clk);
		in_ch.valid <= 1'b1;
		in_ch.op <= op;
		in_ch.sample_mv <= mv;
		do
			@(posedge clk);
		while (!in_ch.ready);
		chk.note_command(op, mv);
		if (op != OP_UNUSED)
			phase_items++;
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		chk.write_reg(idx, data);
	endtask

	// wait for the block to go idle, then load all registers
	task automatic load_config(logic [15:0] def_thr, logic [15:0] hold, logic [15:0] full,
		logic [15:0] per_cell, logic [15:0] beep);
		idle_input(1);
		while (chk.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		write_reg(bat_alarm_pkg::REG_DEFAULT_THRESHOLD, def_thr);
		write_reg(bat_alarm_pkg::REG_HOLD, hold);
		write_reg(bat_alarm_pkg::REG_CELL_FULL, full);
		write_reg(bat_alarm_pkg::REG_CELL_ALARM, per_cell);
		write_reg(bat_alarm_pkg::REG_BEEP_HALF_PERIOD, beep);
		@(negedge clk);
		cfg_we <= 1'b0;
		burst_left = 0;
		steady = $urandom_range(0, 3) == 0;
	endtask

	function automatic logic [15:0] low_voltage();
		int t;
		t = int'(chk.thr);
		if ($urandom_range(0, 2) == 0)
			return t[15:0];
		return 16'($urandom_range(0, t));
	endfunction

	function automatic logic [15:0] high_voltage();
		int t;
		t = int'(chk.thr);
		if (t == 65535)
			return 16'($urandom_range(0, 65535));
		if ($urandom_range(0, 2) == 0)
			return t[15:0] + 16'd1;
		return 16'($urandom_range(t + 1, 65535));
	endfunction

	// low voltage episode: hold, raise, beep and usually recover
	task automatic alarm_episode();
		int n;
		issue(bat_alarm_pkg::OP_SAMPLE, low_voltage());
		n = (chk.hold_ms <= 40) ? $urandom_range(0, chk.hold_ms + 3) : $urandom_range(0, 40);
		repeat (n) issue(bat_alarm_pkg::OP_TICK, 16'($urandom));
		issue(bat_alarm_pkg::OP_SAMPLE, low_voltage());
		n = (chk.beep_half <= 8) ? $urandom_range(0, 3 * chk.beep_half + 3) : $urandom_range(0, 30);
		repeat (n) issue(bat_alarm_pkg::OP_TICK, 16'($urandom));
		if ($urandom_range(0, 4) == 0)
			issue(bat_alarm_pkg::OP_DETECT, 16'($urandom));
		if ($urandom_range(0, 4) != 0)
			issue(bat_alarm_pkg::OP_SAMPLE, high_voltage());
	endtask

	// stray commands with random content
	task automatic noise_items();
		int r;
		repeat ($urandom_range(1, 5)) begin
			r = $urandom_range(0, 99);
			if (r < 40)
				issue(bat_alarm_pkg::OP_TICK, 16'($urandom));
			else if (r < 75)
				issue(bat_alarm_pkg::OP_SAMPLE,
					($urandom_range(0, 1) != 0) ? low_voltage() : high_voltage());
			else if (r < 85)
				issue(bat_alarm_pkg::OP_SAMPLE, 16'($urandom));
			else if (r < 95)
				issue(bat_alarm_pkg::OP_DETECT, 16'($urandom));
			else
				issue(OP_UNUSED, 16'($urandom));
		end
	endtask

	// stimulus
	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.op = bat_alarm_pkg::OP_SAMPLE;
		in_ch.sample_mv = '0;
		burst_left = 0;
		steady = 1'b0;
		phase_items = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: detection without sample, unused op, threshold edges
		issue(bat_alarm_pkg::OP_DETECT, 16'hffff);
		issue(OP_UNUSED, 16'hffff);
		issue(bat_alarm_pkg::OP_TICK, 16'h0000);
		issue(bat_alarm_pkg::OP_SAMPLE, 16'd3300);
		issue(bat_alarm_pkg::OP_SAMPLE, 16'd3300);
		issue(bat_alarm_pkg::OP_SAMPLE, 16'd3301);
		issue(bat_alarm_pkg::OP_SAMPLE, 16'hffff);
		issue(bat_alarm_pkg::OP_DETECT, 16'h0000);
		issue(bat_alarm_pkg::OP_SAMPLE, 16'h0000);
		issue(bat_alarm_pkg::OP_DETECT, 16'h5555);

		// zero hold, zero half period, zero cell voltage and threshold saturation
		load_config(16'd1000, 16'd0, 16'd0, 16'd8191, 16'd0);
		issue(bat_alarm_pkg::OP_SAMPLE, 16'd500);
		issue(bat_alarm_pkg::OP_SAMPLE, 16'd0);
		issue(bat_alarm_pkg::OP_TICK, 16'haaaa);
		issue(bat_alarm_pkg::OP_TICK, 16'h5555);
		issue(bat_alarm_pkg::OP_TICK, 16'h0000);
		issue(bat_alarm_pkg::OP_SAMPLE, 16'd1001);
		issue(bat_alarm_pkg::OP_DETECT, 16'h0000);
		issue(bat_alarm_pkg::OP_SAMPLE, 16'hffff);
		issue(OP_UNUSED, 16'h0000);

		// random phases, the first ones at the register extremes
		for (int p = 1; p <= RANDOM_PHASES; p++) begin
			case (p)
				1: load_config(16'd0, 16'd0, 16'd1, 16'd0, 16'd1);
				2: load_config(16'hffff, 16'hffff, 16'hffff, 16'd8191, 16'hffff);
				3: load_config(16'($urandom), 16'($urandom_range(0, 10)), 16'd0,
					16'($urandom_range(0, 8191)), 16'd0);
				default: load_config(16'($urandom), 16'($urandom_range(0, 25)),
					($urandom_range(0, 4) == 0) ? 16'($urandom_range(1, 65535)) :
					16'($urandom_range(1, 9000)),
					16'($urandom_range(0, 8191)), 16'($urandom_range(1, 5)));
			endcase
			phase_items = 0;
			while (phase_items < PHASE_ITEMS) begin
				if ($urandom_range(0, 3) != 0)
					alarm_episode();
				else
					noise_items();
			end
		end

		// drain
		idle_input(1);
		while (chk.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (chk.errors == 0)
			$display("[battery_low_voltage_alarm] OK");
		else
			$display("[battery_low_voltage_alarm] ERROR");
		$finish;
	end

endmodule
